[hdl/nsc_pkg.sv]
// ----------------------------------------------------------------------------
// nsc_pkg: shared types and constants for the near segment cull block
// Payload structs, register indexes, verdict codes and fixed-point limits.
// ----------------------------------------------------------------------------
package nsc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Z  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LON_LIM  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LAT_LIM  = 3'd7;

    localparam logic [1:0] VERDICT_KEEP    = 2'd0;
    localparam logic [1:0] VERDICT_SHORT   = 2'd1;
    localparam logic [1:0] VERDICT_BEHIND  = 2'd2;
    localparam logic [1:0] VERDICT_OUTSIDE = 2'd3;

    localparam logic [63:0] MIN_SQUARED_LENGTH = 64'd1049;
    localparam logic [16:0] MU_ONE             = 17'd65536;

    localparam int DIV_STEPS   = 16;
    localparam int PRJ_STAGES  = 4 + DIV_STEPS;
    localparam int ELL_STAGES  = 7;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic signed [31:0] end_z;
    } t_seg_in;

    typedef struct packed {
        logic       keep;
        logic [1:0] verdict;
    } t_cull_out;

    typedef struct packed {
        logic [2:0][47:0] rot;
        logic [2:0][31:0] shift;
        logic [19:0]      lon_limit;
        logic [19:0]      lat_limit;
    } t_cfg;

    // vehicle-frame endpoints, 31-bit signed coordinates
    typedef struct packed {
        logic [2:0][30:0] f;
        logic [2:0][30:0] g;
    } t_xf;

    typedef struct packed {
        logic [2:0][30:0] f;
        logic [2:0][31:0] d;
        logic             short_seg;
        logic [16:0]      mu;
    } t_prj;

    typedef struct packed {
        logic [2:0][30:0] f;
        logic [2:0][31:0] d;
        logic [63:0]      den;
        logic [63:0]      rem;
        logic [15:0]      quo;
        logic             short_seg;
        logic             lo;
        logic             hi;
    } t_div;

endpackage

[hdl/nsc_xform.sv]
// ----------------------------------------------------------------------------
// nsc_xform: map to vehicle frame transform
// Two stages: nine Q1.14 products per endpoint, then row sum, rounding,
// translation and saturation to 31-bit coordinates.
// ----------------------------------------------------------------------------
module nsc_xform (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  nsc_pkg::t_cfg   i_cfg,
    input  logic            i_valid,
    output logic            o_ready,
    input  nsc_pkg::t_seg_in i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output nsc_pkg::t_xf    o_data
);
    import nsc_pkg::*;

    function automatic logic [30:0] row_to_coord(
        input logic signed [47:0] a,
        input logic signed [47:0] b,
        input logic signed [47:0] c,
        input logic signed [31:0] t
    );
        logic signed [49:0] s;
        logic signed [35:0] q;
        logic signed [36:0] v;
        s = 50'(a) + 50'(b) + 50'(c) + 50'sd8192;
        q = 36'(s >>> 14);
        v = 37'(q) + 37'(t);
        if (v > 37'sd1073741823) begin
            return 31'h3FFFFFFF;
        end else if (v < -37'sd1073741824) begin
            return 31'h40000000;
        end else begin
            return v[30:0];
        end
    endfunction

    logic signed [31:0] pt [2][3];
    logic signed [47:0] r_prod [2][3][3];
    logic               r_vld1;
    logic               r_vld2;
    t_xf                r_out;
    t_xf                n_out;
    logic               en1;
    logic               en2;

    assign pt[0][0] = i_data.start_x;
    assign pt[0][1] = i_data.start_y;
    assign pt[0][2] = i_data.start_z;
    assign pt[1][0] = i_data.end_x;
    assign pt[1][1] = i_data.end_y;
    assign pt[1][2] = i_data.end_z;

    assign en2     = !r_vld2 || i_ready;
    assign en1     = !r_vld1 || en2;
    assign o_ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            if (en1) begin
                r_vld1 <= i_valid;
            end
            if (en2) begin
                r_vld2 <= r_vld1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            for (int e = 0; e < 2; e++) begin
                for (int r = 0; r < 3; r++) begin
                    for (int c = 0; c < 3; c++) begin
                        r_prod[e][r][c] <= $signed(i_cfg.rot[r][47-16*c -: 16]) * pt[e][c];
                    end
                end
            end
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_out.f[r] = row_to_coord(r_prod[0][r][0], r_prod[0][r][1], r_prod[0][r][2],
                                      $signed(i_cfg.shift[r]));
            n_out.g[r] = row_to_coord(r_prod[1][r][0], r_prod[1][r][1], r_prod[1][r][2],
                                      $signed(i_cfg.shift[r]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_vld2;
    assign o_data  = r_out;

endmodule

[hdl/nsc_proj.sv]
// ----------------------------------------------------------------------------
// nsc_proj: nearest-point parameter
// Direction, squared length and dot product, clamp flags, then a 16-stage
// restoring divider that yields the Q1.16 parameter mu.
// ----------------------------------------------------------------------------
module nsc_proj (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  nsc_pkg::t_xf  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output nsc_pkg::t_prj o_data
);
    import nsc_pkg::*;

    logic [PRJ_STAGES-1:0] r_vld;
    logic [PRJ_STAGES-1:0] en;

    logic [2:0][30:0]   r1_f;
    logic [2:0][31:0]   r1_d;
    logic [2:0][30:0]   r2_f;
    logic [2:0][31:0]   r2_d;
    logic [63:0]        r2_sqp [3];
    logic signed [62:0] r2_dp [3];
    logic [2:0][30:0]   r3_f;
    logic [2:0][31:0]   r3_d;
    logic [63:0]        r3_sq;
    logic signed [64:0] r3_num;
    t_div               r_div [DIV_STEPS+1];
    t_div               n_div [DIV_STEPS];
    t_div               n_div0;

    always_comb begin
        en[PRJ_STAGES-1] = !r_vld[PRJ_STAGES-1] || i_ready;
        for (int k = PRJ_STAGES-2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < PRJ_STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_f <= i_data.f;
            for (int i = 0; i < 3; i++) begin
                r1_d[i] <= 32'($signed(i_data.g[i])) - 32'($signed(i_data.f[i]));
            end
        end
        if (en[1]) begin
            r2_f <= r1_f;
            r2_d <= r1_d;
            for (int i = 0; i < 3; i++) begin
                r2_sqp[i] <= $signed(r1_d[i]) * $signed(r1_d[i]);
                r2_dp[i]  <= $signed(r1_f[i]) * $signed(r1_d[i]);
            end
        end
        if (en[2]) begin
            r3_f   <= r2_f;
            r3_d   <= r2_d;
            r3_sq  <= r2_sqp[0] + r2_sqp[1] + r2_sqp[2];
            r3_num <= -(65'(r2_dp[0]) + 65'(r2_dp[1]) + 65'(r2_dp[2]));
        end
        if (en[3]) begin
            r_div[0] <= n_div0;
        end
        for (int k = 0; k < DIV_STEPS; k++) begin
            if (en[4+k]) begin
                r_div[k+1] <= n_div[k];
            end
        end
    end

    always_comb begin
        n_div0.f         = r3_f;
        n_div0.d         = r3_d;
        n_div0.den       = r3_sq;
        n_div0.rem       = r3_num[63:0];
        n_div0.quo       = '0;
        n_div0.short_seg = r3_sq < MIN_SQUARED_LENGTH;
        n_div0.lo        = r3_num <= 65'sd0;
        n_div0.hi        = !(r3_num <= 65'sd0) && (r3_num[63:0] >= r3_sq);
    end

    // one quotient bit per stage
    always_comb begin
        for (int k = 0; k < DIV_STEPS; k++) begin
            logic [64:0] sh;
            sh = {r_div[k].rem, 1'b0};
            n_div[k] = r_div[k];
            if (sh >= {1'b0, r_div[k].den}) begin
                n_div[k].rem = 64'(sh - {1'b0, r_div[k].den});
                n_div[k].quo = {r_div[k].quo[DIV_STEPS-2:0], 1'b1};
            end else begin
                n_div[k].rem = sh[63:0];
                n_div[k].quo = {r_div[k].quo[DIV_STEPS-2:0], 1'b0};
            end
        end
    end

    assign o_valid          = r_vld[PRJ_STAGES-1];
    assign o_data.f         = r_div[DIV_STEPS].f;
    assign o_data.d         = r_div[DIV_STEPS].d;
    assign o_data.short_seg = r_div[DIV_STEPS].short_seg;
    assign o_data.mu        = r_div[DIV_STEPS].hi ? MU_ONE :
                              r_div[DIV_STEPS].lo ? 17'd0 :
                              {1'b0, r_div[DIV_STEPS].quo};

    a_clamp_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] && !r_div[0].short_seg |-> !(r_div[0].lo && r_div[0].hi))
        else $error("both clamp flags set on a long segment");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[PRJ_STAGES-1] && !r_div[DIV_STEPS].short_seg && !r_div[DIV_STEPS].lo
        && !r_div[DIV_STEPS].hi |-> r_div[DIV_STEPS].rem < r_div[DIV_STEPS].den)
        else $error("divider remainder not below divisor");

endmodule

[hdl/nsc_ellipse.sv]
// ----------------------------------------------------------------------------
// nsc_ellipse: nearest point and ellipse test
// Nearest point from mu, behind and bounding-box checks, then the exact
// ellipse compare with squares built from 20x20 partial products.
// ----------------------------------------------------------------------------
module nsc_ellipse (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  nsc_pkg::t_cfg      i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  nsc_pkg::t_prj      i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output nsc_pkg::t_cull_out o_data
);
    import nsc_pkg::*;

    logic [ELL_STAGES-1:0] r_vld;
    logic [ELL_STAGES-1:0] en;

    logic [2:0][30:0]   r1_f;
    logic signed [49:0] r1_pm [3];
    logic               r1_short;
    logic signed [33:0] r2_n0;
    logic signed [33:0] r2_n1;
    logic               r2_short;
    logic [33:0]        ay;
    logic               behind;
    logic               out_box;
    logic [1:0]         r3_code;
    logic [19:0]        r3_ax;
    logic [19:0]        r3_ay;
    logic [1:0]         r4_code;
    logic [39:0]        r4_x [3];
    logic [1:0]         r5_code;
    logic [39:0]        r5_hh [3];
    logic [39:0]        r5_hl [3];
    logic [39:0]        r5_ll [3];
    logic [79:0]        sq [3];
    logic [1:0]         r6_code;
    logic [80:0]        r6_pq;
    logic [79:0]        r6_rr;
    t_cull_out          r_out;

    always_comb begin
        en[ELL_STAGES-1] = !r_vld[ELL_STAGES-1] || i_ready;
        for (int k = ELL_STAGES-2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < ELL_STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_comb begin
        behind  = r2_n0[33];
        ay      = r2_n1[33] ? 34'(-r2_n1) : 34'(r2_n1);
        out_box = (r2_n0 >= $signed(34'(i_cfg.lon_limit))) || (ay >= 34'(i_cfg.lat_limit));
        for (int i = 0; i < 3; i++) begin
            sq[i] = {r5_hh[i], 40'd0} + 80'({r5_hl[i], 21'd0}) + 80'(r5_ll[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_f     <= i_data.f;
            r1_short <= i_data.short_seg;
            for (int i = 0; i < 3; i++) begin
                r1_pm[i] <= $signed(i_data.d[i]) * $signed({1'b0, i_data.mu});
            end
        end
        if (en[1]) begin
            r2_short <= r1_short;
            r2_n0    <= 34'($signed(r1_f[0])) + 34'(r1_pm[0] >>> 16);
            r2_n1    <= 34'($signed(r1_f[1])) + 34'(r1_pm[1] >>> 16);
        end
        if (en[2]) begin
            if (r2_short) begin
                r3_code <= VERDICT_SHORT;
            end else if (behind) begin
                r3_code <= VERDICT_BEHIND;
            end else if (out_box) begin
                r3_code <= VERDICT_OUTSIDE;
            end else begin
                r3_code <= VERDICT_KEEP;
            end
            r3_ax <= r2_n0[19:0];
            r3_ay <= ay[19:0];
        end
        if (en[3]) begin
            r4_code <= r3_code;
            r4_x[0] <= 40'(r3_ax) * 40'(i_cfg.lat_limit);
            r4_x[1] <= 40'(r3_ay) * 40'(i_cfg.lon_limit);
            r4_x[2] <= 40'(i_cfg.lon_limit) * 40'(i_cfg.lat_limit);
        end
        if (en[4]) begin
            r5_code <= r4_code;
            for (int i = 0; i < 3; i++) begin
                r5_hh[i] <= 40'(r4_x[i][39:20]) * 40'(r4_x[i][39:20]);
                r5_hl[i] <= 40'(r4_x[i][39:20]) * 40'(r4_x[i][19:0]);
                r5_ll[i] <= 40'(r4_x[i][19:0]) * 40'(r4_x[i][19:0]);
            end
        end
        if (en[5]) begin
            r6_code <= r5_code;
            r6_pq   <= 81'(sq[0]) + 81'(sq[1]);
            r6_rr   <= sq[2];
        end
        if (en[6]) begin
            if (r6_code == VERDICT_KEEP && !(r6_pq < 81'(r6_rr))) begin
                r_out.verdict <= VERDICT_OUTSIDE;
                r_out.keep    <= 1'b0;
            end else begin
                r_out.verdict <= r6_code;
                r_out.keep    <= r6_code == VERDICT_KEEP;
            end
        end
    end

    assign o_valid = r_vld[ELL_STAGES-1];
    assign o_data  = r_out;

    a_box_narrow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] && r3_code == VERDICT_KEEP |->
        (r3_ax < i_cfg.lon_limit) && (r3_ay < i_cfg.lat_limit))
        else $error("kept candidate outside bounding box");

    a_keep_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.keep == (o_data.verdict == VERDICT_KEEP))
        else $error("keep flag disagrees with verdict");

endmodule

[hdl/near_segment_cull.sv]
// ----------------------------------------------------------------------------
// near_segment_cull: map segment culling against a vehicle-frame ellipse
// Each input transaction carries one segment (two map-frame endpoints).
// Both endpoints go to the vehicle frame through the configured inverse
// pose; the nearest point of the segment to the vehicle is tested against
// the ellipse and one output transaction returns keep and a verdict code.
// Channels: input and output use valid/ready; the config channel writes
// one register per transaction and is always ready.
// The pipeline has 2 transform stages, 20 projection stages (16 of
// them the divider) and 7 ellipse stages. It is fully staged, so a new
// transaction can enter every cycle while the output is not stalled.
// Reset loads the identity rotation, zero translation and 60 m by 10 m
// limits and empties the pipeline. When the output is stalled, ready
// backs up stage by stage: empty stages still fill, nothing is dropped.
// The user must write config only with the pipeline empty; not enforced.
// ----------------------------------------------------------------------------
module near_segment_cull (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  nsc_pkg::t_seg_in                    i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output nsc_pkg::t_cull_out                  o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [nsc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [nsc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import nsc_pkg::*;

    t_cfg r_cfg;
    logic xf_valid;
    logic xf_ready;
    t_xf  xf_data;
    logic pj_valid;
    logic pj_ready;
    t_prj pj_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rot[0]     <= 48'h4000_0000_0000;
            r_cfg.rot[1]     <= 48'h0000_4000_0000;
            r_cfg.rot[2]     <= 48'h0000_0000_4000;
            r_cfg.shift      <= '0;
            r_cfg.lon_limit  <= 20'd61440;
            r_cfg.lat_limit  <= 20'd10240;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ROT_ROW0: r_cfg.rot[0]    <= i_cfg_data;
                REG_ROT_ROW1: r_cfg.rot[1]    <= i_cfg_data;
                REG_ROT_ROW2: r_cfg.rot[2]    <= i_cfg_data;
                REG_SHIFT_X:  r_cfg.shift[0]  <= i_cfg_data[31:0];
                REG_SHIFT_Y:  r_cfg.shift[1]  <= i_cfg_data[31:0];
                REG_SHIFT_Z:  r_cfg.shift[2]  <= i_cfg_data[31:0];
                REG_LON_LIM:  r_cfg.lon_limit <= i_cfg_data[19:0];
                REG_LAT_LIM:  r_cfg.lat_limit <= i_cfg_data[19:0];
                default: ;
            endcase
        end
    end

    nsc_xform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .o_valid (xf_valid),
        .i_ready (xf_ready),
        .o_data  (xf_data)
    );

    nsc_proj u_proj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (xf_valid),
        .o_ready (xf_ready),
        .i_data  (xf_data),
        .o_valid (pj_valid),
        .i_ready (pj_ready),
        .o_data  (pj_data)
    );

    nsc_ellipse u_ellipse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (pj_valid),
        .o_ready (pj_ready),
        .i_data  (pj_data),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule
